FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Every macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ppc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM prescaler calculator package
// Widths, constants, codes and controller/datapath types shared by the block.
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int PERIOD_BITS = 16;

  localparam int CLK_W      = 27;
  localparam int CODE_W     = 3;
  localparam int TCLK_W     = CLK_W + 1;
  localparam int FREQ_W     = 28;
  localparam int DUTY_W     = 8;
  localparam int PRE_W      = 17;
  localparam int REL_W      = 16;
  localparam int CMP_W      = 18;
  localparam int ST_W       = 2;

  localparam int DVD_W      = TCLK_W;
  localparam int DVS_W      = FREQ_W + PERIOD_BITS + 1;
  localparam int CPROD_W    = PERIOD_BITS + 1 + DUTY_W;
  localparam int CNT_W      = $clog2(DVD_W + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CLK_W;

  localparam int PRESCALE_MAX = 65536;
  localparam int DUTY_DIV     = 100;

  localparam logic [REL_W-1:0]  MAX_RELOAD   = REL_W'((2 ** PERIOD_BITS) - 1);
  localparam logic [CODE_W-1:0] DOUBLE_CODE  = CODE_W'(4);
  localparam logic [CLK_W-1:0]  BUS_CLK_RST  = CLK_W'(42000000);
  localparam logic [CODE_W-1:0] DIV_CODE_RST = CODE_W'(0);

  localparam logic [CFG_IDX_W-1:0] CFG_BUS_CLK  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DIV_CODE = CFG_IDX_W'(1);

  localparam logic [ST_W-1:0] ST_OK       = ST_W'(0);
  localparam logic [ST_W-1:0] ST_BAD_FREQ = ST_W'(1);
  localparam logic [ST_W-1:0] ST_NO_FIT   = ST_W'(2);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_PRE,
    S_MUL_PRE,
    S_START_REL,
    S_DIV_REL,
    S_MUL_CMP,
    S_START_CMP,
    S_DIV_CMP,
    S_FINISH
  } ppc_state_e;

  typedef enum logic [1:0] {
    DSEL_PRE,
    DSEL_REL,
    DSEL_CMP
  } ppc_dsel_e;

  typedef struct packed {
    logic      load_in;
    logic      div_start;
    ppc_dsel_e div_sel;
    logic      take_pre;
    logic      mul_pre;
    logic      take_rel;
    logic      mul_cmp;
    logic      take_cmp;
    logic      set_bad;
    logic      out_load;
  } ppc_cmd_t;

  typedef struct packed {
    logic bad_freq;
    logic no_fit;
    logic div_done;
    logic div_busy;
  } ppc_stat_t;

endpackage

FILE: hw/rtl/ppc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM prescaler calculator channels
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface ppc_in_if;
  logic                         valid;
  logic                         ready;
  logic [ppc_pkg::FREQ_W-1:0]   target_hz;
  logic [ppc_pkg::DUTY_W-1:0]   duty_percent;

  modport source (output valid, output target_hz, output duty_percent, input ready);
  modport sink   (input valid, input target_hz, input duty_percent, output ready);
endinterface

interface ppc_out_if;
  logic                         valid;
  logic                         ready;
  logic [ppc_pkg::PRE_W-1:0]    prescale_setting;
  logic [ppc_pkg::REL_W-1:0]    reload_value;
  logic [ppc_pkg::CMP_W-1:0]    compare_value;
  logic [ppc_pkg::ST_W-1:0]     status;

  modport source (output valid, output prescale_setting, output reload_value,
                  output compare_value, output status, input ready);
  modport sink   (input valid, input prescale_setting, input reload_value,
                  input compare_value, input status, output ready);
endinterface

FILE: hw/rtl/ppc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM prescaler calculator divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ppc_pkg::DVD_W-1:0]   dividend_i,
  input  logic [ppc_pkg::DVS_W-1:0]   divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [ppc_pkg::DVD_W-1:0]   quotient_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [ppc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [ppc_pkg::DVS_W-1:0]   rem_q, rem_d;
  logic [ppc_pkg::DVS_W-1:0]   dvs_q, dvs_d;
  logic [ppc_pkg::DVD_W-1:0]   quo_q, quo_d;
  logic [ppc_pkg::DVS_W:0]     trial;
  logic                        fits;

  // The dividend shifts out of quo_q from the top while quotient bits enter below.
  assign trial = {rem_q, quo_q[ppc_pkg::DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = ppc_pkg::CNT_W'(ppc_pkg::DVD_W);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? ppc_pkg::DVS_W'(trial - {1'b0, dvs_q}) : trial[ppc_pkg::DVS_W-1:0];
      quo_d = {quo_q[ppc_pkg::DVD_W-2:0], fits};
      cnt_d = cnt_q - ppc_pkg::CNT_W'(1);
      if (cnt_q == ppc_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  `PPC_ASSERT_NXT(a_div_done_pulse, done_q, !done_q && !busy_q, "divider done is not a single pulse")

endmodule

FILE: hw/rtl/ppc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM prescaler calculator datapath
// Configuration registers, operand registers, shared divider and result words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppc_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [ppc_pkg::FREQ_W-1:0]      target_hz_i,
  input  logic [ppc_pkg::DUTY_W-1:0]      duty_percent_i,
  input  ppc_pkg::ppc_cmd_t               cmd_i,
  output ppc_pkg::ppc_stat_t              stat_o,
  output logic [ppc_pkg::PRE_W-1:0]       prescale_setting_o,
  output logic [ppc_pkg::REL_W-1:0]       reload_value_o,
  output logic [ppc_pkg::CMP_W-1:0]       compare_value_o,
  output logic [ppc_pkg::ST_W-1:0]        status_o
);

  logic [ppc_pkg::CLK_W-1:0]    bus_clk_q;
  logic [ppc_pkg::CODE_W-1:0]   div_code_q;

  logic [ppc_pkg::TCLK_W-1:0]   tclk_d, tclk_q;
  logic [ppc_pkg::FREQ_W-1:0]   freq_q;
  logic [ppc_pkg::DUTY_W-1:0]   duty_q;
  logic [ppc_pkg::PRE_W-1:0]    p_q;
  logic [ppc_pkg::DVS_W-1:0]    prod_q;
  logic [ppc_pkg::REL_W-1:0]    reload_q;
  logic [ppc_pkg::CPROD_W-1:0]  cprod_q;
  logic [ppc_pkg::CMP_W-1:0]    cmp_q;
  logic [ppc_pkg::ST_W-1:0]     st_q;
  logic                         no_fit_q;

  logic [ppc_pkg::PRE_W-1:0]    out_pre_q;
  logic [ppc_pkg::REL_W-1:0]    out_rel_q;
  logic [ppc_pkg::CMP_W-1:0]    out_cmp_q;
  logic [ppc_pkg::ST_W-1:0]     out_st_q;

  logic [ppc_pkg::DVD_W-1:0]    dvd;
  logic [ppc_pkg::DVS_W-1:0]    dvs;
  logic [ppc_pkg::DVD_W-1:0]    div_quo;
  logic                         div_busy;
  logic                         div_done;
  logic [ppc_pkg::REL_W:0]      rel_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_clk_q  <= ppc_pkg::BUS_CLK_RST;
      div_code_q <= ppc_pkg::DIV_CODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppc_pkg::CFG_BUS_CLK:  bus_clk_q  <= cfg_data_i;
        ppc_pkg::CFG_DIV_CODE: div_code_q <= cfg_data_i[ppc_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign tclk_d = (div_code_q >= ppc_pkg::DOUBLE_CODE) ? {bus_clk_q, 1'b0}
                                                       : {1'b0, bus_clk_q};

  // Divider operands for the three quotients: prescaler, reload and compare.
  always_comb begin
    dvd = tclk_q;
    dvs = ppc_pkg::DVS_W'({freq_q, {ppc_pkg::PERIOD_BITS{1'b0}}})
        + ppc_pkg::DVS_W'(freq_q);
    unique case (cmd_i.div_sel)
      ppc_pkg::DSEL_PRE: ;
      ppc_pkg::DSEL_REL: dvs = prod_q;
      ppc_pkg::DSEL_CMP: begin
        dvd = ppc_pkg::DVD_W'(cprod_q);
        dvs = ppc_pkg::DVS_W'(ppc_pkg::DUTY_DIV);
      end
      default: ;
    endcase
  end

  ppc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign rel_inc = {1'b0, reload_q} + (ppc_pkg::REL_W + 1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_fit_q <= 1'b0;
    end else if (cmd_i.take_pre) begin
      no_fit_q <= (div_quo >= ppc_pkg::DVD_W'(ppc_pkg::PRESCALE_MAX));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      freq_q <= target_hz_i;
      duty_q <= duty_percent_i;
      tclk_q <= tclk_d;
    end
    if (cmd_i.set_bad) begin
      p_q      <= ppc_pkg::PRE_W'(1);
      reload_q <= '0;
      cmp_q    <= '0;
      st_q     <= ppc_pkg::ST_BAD_FREQ;
    end
    if (cmd_i.take_pre) begin
      if (div_quo >= ppc_pkg::DVD_W'(ppc_pkg::PRESCALE_MAX)) begin
        p_q      <= ppc_pkg::PRE_W'(ppc_pkg::PRESCALE_MAX);
        reload_q <= ppc_pkg::MAX_RELOAD;
        st_q     <= ppc_pkg::ST_NO_FIT;
      end else begin
        p_q  <= div_quo[ppc_pkg::PRE_W-1:0] + ppc_pkg::PRE_W'(1);
        st_q <= ppc_pkg::ST_OK;
      end
    end
    if (cmd_i.mul_pre) begin
      prod_q <= ppc_pkg::DVS_W'(p_q) * ppc_pkg::DVS_W'(freq_q);
    end
    if (cmd_i.take_rel) begin
      reload_q <= ppc_pkg::REL_W'(div_quo - ppc_pkg::DVD_W'(1));
    end
    if (cmd_i.mul_cmp) begin
      cprod_q <= ppc_pkg::CPROD_W'(rel_inc) * ppc_pkg::CPROD_W'(duty_q);
    end
    if (cmd_i.take_cmp) begin
      cmp_q <= div_quo[ppc_pkg::CMP_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_pre_q <= p_q - ppc_pkg::PRE_W'(1);
      out_rel_q <= reload_q;
      out_cmp_q <= cmp_q;
      out_st_q  <= st_q;
    end
  end

  assign stat_o.bad_freq = (freq_q == '0) || (ppc_pkg::TCLK_W'(freq_q) > tclk_q);
  assign stat_o.no_fit   = no_fit_q;
  assign stat_o.div_done = div_done;
  assign stat_o.div_busy = div_busy;

  assign prescale_setting_o = out_pre_q;
  assign reload_value_o     = out_rel_q;
  assign compare_value_o    = out_cmp_q;
  assign status_o           = out_st_q;

  // The reload quotient is at least one, so reload minus one never wraps.
  `PPC_ASSERT_IMP(a_rel_quo_nonzero, cmd_i.take_rel, div_quo != '0, "reload quotient is zero")

endmodule

FILE: hw/rtl/ppc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM prescaler calculator controller
// Sequences the datapath and owns the request and result handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ppc_pkg::ppc_cmd_t    cmd_o,
  input  ppc_pkg::ppc_stat_t   stat_i
);

  ppc_pkg::ppc_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  // The result register can take a new word when empty or when drained this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppc_pkg::S_IDLE:      if (in_valid_i) state_d = ppc_pkg::S_CHECK;
      ppc_pkg::S_CHECK:     state_d = stat_i.bad_freq ? ppc_pkg::S_FINISH : ppc_pkg::S_DIV_PRE;
      ppc_pkg::S_DIV_PRE:   if (stat_i.div_done) state_d = ppc_pkg::S_MUL_PRE;
      ppc_pkg::S_MUL_PRE:   state_d = stat_i.no_fit ? ppc_pkg::S_MUL_CMP : ppc_pkg::S_START_REL;
      ppc_pkg::S_START_REL: state_d = ppc_pkg::S_DIV_REL;
      ppc_pkg::S_DIV_REL:   if (stat_i.div_done) state_d = ppc_pkg::S_MUL_CMP;
      ppc_pkg::S_MUL_CMP:   state_d = ppc_pkg::S_START_CMP;
      ppc_pkg::S_START_CMP: state_d = ppc_pkg::S_DIV_CMP;
      ppc_pkg::S_DIV_CMP:   if (stat_i.div_done) state_d = ppc_pkg::S_FINISH;
      ppc_pkg::S_FINISH:    if (out_free) state_d = ppc_pkg::S_IDLE;
      default:              state_d = ppc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = ppc_pkg::DSEL_PRE;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ppc_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ppc_pkg::S_CHECK: begin
        cmd_o.set_bad   = stat_i.bad_freq;
        cmd_o.div_start = !stat_i.bad_freq;
      end
      ppc_pkg::S_DIV_PRE:   cmd_o.take_pre = stat_i.div_done;
      ppc_pkg::S_MUL_PRE:   cmd_o.mul_pre = 1'b1;
      ppc_pkg::S_START_REL: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = ppc_pkg::DSEL_REL;
      end
      ppc_pkg::S_DIV_REL:   cmd_o.take_rel = stat_i.div_done;
      ppc_pkg::S_MUL_CMP:   cmd_o.mul_cmp = 1'b1;
      ppc_pkg::S_START_CMP: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = ppc_pkg::DSEL_CMP;
      end
      ppc_pkg::S_DIV_CMP:   cmd_o.take_cmp = stat_i.div_done;
      ppc_pkg::S_FINISH:    cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `PPC_ASSERT_IMP(a_start_when_idle, cmd_o.div_start, !stat_i.div_busy, "divider restarted while busy")
  `PPC_ASSERT_NXT(a_finish_shows, (state_q == ppc_pkg::S_FINISH) && out_free, out_valid_q, "finished word not shown")

endmodule

FILE: hw/rtl/pwm_prescaler_period_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM prescaler and period calculator
// Turns a PWM frequency and duty request into 16-bit timer settings.
// ----------------------------------------------------------------------------
// A request runs up to three 28-step divisions on one shared restoring divider:
// two when no prescaler fits and none for a bad frequency. One request is in
// work at a time; the next is accepted in the cycle after the result register
// is loaded, even while that word still waits for the sink. Reset (asynchronous,
// active low) empties the result register, idles the controller and loads the
// configuration reset values.
// ----------------------------------------------------------------------------
//
// Operation
//   The timer clock is the bus clock, doubled when the bus divider code is four
//   or more. A request whose frequency is zero or above the timer clock finishes
//   at once with zero settings and the bad-frequency status.
//   Otherwise the shared divider runs three times:
//     1. timer clock / (frequency * (2^16 + 1)) gives the prescaler minus one,
//        since the smallest prescaler p with clock < (65537) * p * frequency is
//        that quotient plus one. A quotient of 65536 or more means no prescaler
//        fits: p saturates at 65536, reload at 65535 and the status says so.
//     2. timer clock / (p * frequency) minus one gives the reload value.
//     3. (reload + 1) * duty / 100 gives the compare value.
//   The two products are each one registered multiply between divisions.
//
// Configuration writes are taken at any time but are meant for idle periods;
// the timer clock is sampled when a request is accepted.

module pwm_prescaler_period_calc (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  ppc_in_if.sink                          in_i,
  ppc_out_if.source                       out_o
);

  ppc_pkg::ppc_cmd_t  cmd;
  ppc_pkg::ppc_stat_t stat;

  // Controller: sequence of divisions and multiplies, plus both handshakes.
  ppc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Datapath: configuration registers, operands, divider and the result word.
  ppc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .target_hz_i        (in_i.target_hz),
    .duty_percent_i     (in_i.duty_percent),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .prescale_setting_o (out_o.prescale_setting),
    .reload_value_o     (out_o.reload_value),
    .compare_value_o    (out_o.compare_value),
    .status_o           (out_o.status)
  );

endmodule

FILE: tb/pwm_prescaler_period_calc_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM prescaler and period calculator testbench
// Drives frequency and duty requests into the calculator. It runs a set of
// directed rows and then random requests under several bus clock settings. It
// checks every result word against a typed expected word or a local model.
// ----------------------------------------------------------------------------
module pwm_prescaler_period_calc_tb;

  // Clock period is 4 ns. The cycle limit covers the 616 requests, plus sender
  // gaps, sink stalls and drains between settings, with a wide margin.
  localparam int          RESET_CYCLES     = 10;
  localparam int          ITEMS_PER_SETUP  = 60;
  localparam int          TAIL_CYCLES      = 120;
  localparam int          CYCLE_LIMIT      = 600_000;
  localparam longint unsigned FREQ_MAX     = (64'd1 << ppc_pkg::FREQ_W) - 1;
  localparam logic [ppc_pkg::CLK_W-1:0] BUS_CLK_MAX = {ppc_pkg::CLK_W{1'b1}};

  // Indexes past the end of the register list. The block must ignore writes
  // to them.
  localparam logic [ppc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = ppc_pkg::CFG_IDX_W'(2);
  localparam logic [ppc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = ppc_pkg::CFG_IDX_W'(3);

  typedef struct packed {
    logic [ppc_pkg::PRE_W-1:0] prescale;
    logic [ppc_pkg::REL_W-1:0] reload;
    logic [ppc_pkg::CMP_W-1:0] compare;
    logic [ppc_pkg::ST_W-1:0]  status;
  } timer_setting_t;

  typedef struct packed {
    logic [ppc_pkg::FREQ_W-1:0] target;
    logic [ppc_pkg::DUTY_W-1:0] duty;
    bit                         typed;
    timer_setting_t             want;
  } plan_row_t;

  typedef struct packed {
    logic [ppc_pkg::CLK_W-1:0]  bus_clk;
    logic [ppc_pkg::CODE_W-1:0] code;
  } clock_setup_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE
  } sink_mode_e;

  localparam timer_setting_t UNTYPED = '0;

  // These rows use the reset configuration, so the timer clock is 42 MHz. A
  // typed row carries its own expected word. Those are the error rows and the
  // rows where the frequency equals the timer clock, which gives prescaler 1
  // and reload 0. All other rows are checked against the model.
  localparam int PLAN_ROWS = 16;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    '{28'd0,          8'd50,  1'b1, '{17'd0, 16'd0, 18'd0, ppc_pkg::ST_BAD_FREQ}},
    '{28'd42000001,   8'd50,  1'b1, '{17'd0, 16'd0, 18'd0, ppc_pkg::ST_BAD_FREQ}},
    '{28'hFFFFFFF,    8'd255, 1'b1, '{17'd0, 16'd0, 18'd0, ppc_pkg::ST_BAD_FREQ}},
    '{28'h5555555,    8'hAA,  1'b1, '{17'd0, 16'd0, 18'd0, ppc_pkg::ST_BAD_FREQ}},
    '{28'd42000000,   8'd100, 1'b1, '{17'd0, 16'd0, 18'd1, ppc_pkg::ST_OK}},
    '{28'd42000000,   8'd255, 1'b1, '{17'd0, 16'd0, 18'd2, ppc_pkg::ST_OK}},
    '{28'd42000000,   8'd0,   1'b1, '{17'd0, 16'd0, 18'd0, ppc_pkg::ST_OK}},
    '{28'd1,          8'd50,  1'b0, UNTYPED},
    '{28'd1,          8'd255, 1'b0, UNTYPED},
    '{28'd640,        8'd100, 1'b0, UNTYPED},
    '{28'd641,        8'd100, 1'b0, UNTYPED},
    '{28'd21000000,   8'd50,  1'b0, UNTYPED},
    '{28'd1000,       8'd33,  1'b0, UNTYPED},
    '{28'd20000,      8'd101, 1'b0, UNTYPED},
    '{28'h0AAAAAA,    8'h55,  1'b0, UNTYPED},
    '{28'd41999999,   8'd100, 1'b0, UNTYPED}
  };

  // The settings run one after another. The first one is the reset state and
  // is never written. The list holds a zero bus clock, where every request is
  // a bad frequency, and the smallest and largest clocks on both sides of the
  // doubling threshold. Two random settings follow in the stimulus loop.
  localparam int FIXED_SETUPS = 8;
  localparam clock_setup_t CLOCK_SETUPS [FIXED_SETUPS] = '{
    '{ppc_pkg::BUS_CLK_RST,                  ppc_pkg::DIV_CODE_RST},
    '{ppc_pkg::CLK_W'(0),                    ppc_pkg::CODE_W'(5)},
    '{ppc_pkg::CLK_W'(1),                    ppc_pkg::CODE_W'(0)},
    '{ppc_pkg::CLK_W'(1),                    ppc_pkg::CODE_W'(7)},
    '{BUS_CLK_MAX,                           ppc_pkg::CODE_W'(7)},
    '{BUS_CLK_MAX,                           ppc_pkg::CODE_W'(3)},
    '{ppc_pkg::CLK_W'(100_000_000),          ppc_pkg::DOUBLE_CODE},
    '{ppc_pkg::BUS_CLK_RST,                  ppc_pkg::DOUBLE_CODE}
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [ppc_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [ppc_pkg::CFG_DATA_W-1:0] cfg_data_i;

  ppc_in_if  req_if ();
  ppc_out_if res_if ();

  pwm_prescaler_period_calc dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if),
    .out_o      (res_if)
  );

  // Local copy of the configuration registers. It changes only while the
  // block is idle, so the value at request time is the one the block samples.
  logic [ppc_pkg::CLK_W-1:0]  bus_clk_model;
  logic [ppc_pkg::CODE_W-1:0] div_code_model;

  timer_setting_t pending_settings [$];
  int unsigned    mismatch_count;
  int unsigned    cycle_count;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic longint unsigned timer_clock_model();
    longint unsigned tclk;
    tclk = 64'(bus_clk_model);
    if (div_code_model >= ppc_pkg::DOUBLE_CODE) begin
      tclk = tclk << 1;
    end
    return tclk;
  endfunction

  // This is the expected result word for one request. The prescaler is the
  // smallest p for which clock / (p * freq) - 1 still fits in the period
  // width. With a 16-bit period and a clock of at most 28 bits, p always
  // fits. The no-fit branch is kept so that the model stays complete.
  function automatic timer_setting_t predict_setting(logic [ppc_pkg::FREQ_W-1:0] freq,
                                                     logic [ppc_pkg::DUTY_W-1:0] duty);
    longint unsigned tclk, span, pre, rel, cmp;
    timer_setting_t  word;
    tclk = timer_clock_model();
    span = 64'(ppc_pkg::MAX_RELOAD) + 2;
    word = '0;
    if (freq == 0 || 64'(freq) > tclk) begin
      word.status = ppc_pkg::ST_BAD_FREQ;
      return word;
    end
    pre = tclk / (64'(freq) * span) + 1;
    if (pre > 64'(ppc_pkg::PRESCALE_MAX)) begin
      pre         = 64'(ppc_pkg::PRESCALE_MAX);
      rel         = 64'(ppc_pkg::MAX_RELOAD);
      word.status = ppc_pkg::ST_NO_FIT;
    end else begin
      rel         = tclk / (pre * 64'(freq)) - 1;
      word.status = ppc_pkg::ST_OK;
    end
    cmp           = ((rel + 1) * 64'(duty)) / 64'(ppc_pkg::DUTY_DIV);
    word.prescale = ppc_pkg::PRE_W'(pre - 1);
    word.reload   = ppc_pkg::REL_W'(rel);
    word.compare  = ppc_pkg::CMP_W'(cmp);
    return word;
  endfunction

  // Most frequencies are valid and spread over a log scale, so that many
  // prescalers come up. Some requests hit the edges: zero, exactly the timer
  // clock, the point where the prescaler steps from 1 to 2, above the clock,
  // and fully random 28-bit values.
  function automatic logic [ppc_pkg::FREQ_W-1:0] pick_target();
    longint unsigned tclk, v;
    int unsigned     mode;
    tclk = timer_clock_model();
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      v = 0;
    end else if (mode <= 2) begin
      v = 64'($urandom) & FREQ_MAX;
    end else if (mode <= 4) begin
      v = tclk + 1 + 64'($urandom >> $urandom_range(4, 31));
    end else if (mode == 5) begin
      v = tclk;
    end else if (mode == 6) begin
      v = tclk / (64'(ppc_pkg::MAX_RELOAD) + 2) + $urandom_range(0, 2);
    end else if (tclk == 0) begin
      v = 64'($urandom) & FREQ_MAX;
    end else begin
      v = (64'($urandom >> $urandom_range(0, 31)) % tclk) + 1;
    end
    if (v > FREQ_MAX) begin
      v = FREQ_MAX;
    end
    return ppc_pkg::FREQ_W'(v);
  endfunction

  function automatic logic [ppc_pkg::DUTY_W-1:0] pick_duty();
    if ($urandom_range(0, 3) == 0) begin
      return ppc_pkg::DUTY_W'($urandom_range(0, 255));
    end
    return ppc_pkg::DUTY_W'($urandom_range(0, ppc_pkg::DUTY_DIV));
  endfunction

  // Presents one request at the falling edge and holds it until a rising
  // edge sees ready. Valid stays high afterwards. The next call, or a gap,
  // changes it at the next falling edge.
  task automatic send_request(input logic [ppc_pkg::FREQ_W-1:0] freq,
                              input logic [ppc_pkg::DUTY_W-1:0] duty,
                              input bit typed, input timer_setting_t typed_want);
    @(negedge clk_i);
    req_if.valid        <= 1'b1;
    req_if.target_hz    <= freq;
    req_if.duty_percent <= duty;
    do @(posedge clk_i); while (!req_if.ready);
    pending_settings.push_back(typed ? typed_want : predict_setting(freq, duty));
  endtask

  task automatic hold_off(input int unsigned cycles);
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Drops valid and waits until every outstanding word has been received.
  // Each request gives exactly one word, so an empty queue means the block
  // is idle.
  task automatic drain_results();
    hold_off(1);
    while (pending_settings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ppc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ppc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      ppc_pkg::CFG_BUS_CLK:  bus_clk_model  = data[ppc_pkg::CLK_W-1:0];
      ppc_pkg::CFG_DIV_CODE: div_code_model = data[ppc_pkg::CODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string field, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Every accepted result word is compared with the oldest pending
  // expectation. A word that arrives with nothing pending is an error too.
  always @(posedge clk_i) begin : result_check
    timer_setting_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_settings.size() == 0) begin
        $display("%0t ns: result word expected none, actual pre %0d rel %0d cmp %0d st %0d",
                 $time, res_if.prescale_setting, res_if.reload_value,
                 res_if.compare_value, res_if.status);
        mismatch_count++;
      end else begin
        want = pending_settings.pop_front();
        check_field("prescale_setting", want.prescale, res_if.prescale_setting);
        check_field("reload_value",     want.reload,   res_if.reload_value);
        check_field("compare_value",    want.compare,  res_if.compare_value);
        check_field("status",           want.status,   res_if.status);
      end
    end
  end

  // The sink switches between open, coin-flip and sparse ready patterns. Each
  // pattern lasts a random number of cycles, so results wait for different
  // lengths of time and some stretches have no stall at all.
  initial begin : sink_pattern
    sink_mode_e  mode;
    int unsigned left;
    mode         = SINK_OPEN;
    left         = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = sink_mode_e'($urandom_range(0, 2));
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        SINK_OPEN:   res_if.ready <= 1'b1;
        SINK_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
        SINK_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
        default:     res_if.ready <= 1'b1;
      endcase
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t ns: cycle limit reached with %0d words pending", $time,
                 pending_settings.size());
        $display("pwm_prescaler_period_calc: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    clock_setup_t setup;
    int unsigned  burst_left;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = ppc_pkg::CFG_BUS_CLK;
    cfg_data_i          = '0;
    req_if.valid        = 1'b0;
    req_if.target_hz    = '0;
    req_if.duty_percent = '0;
    bus_clk_model       = ppc_pkg::BUS_CLK_RST;
    div_code_model      = ppc_pkg::DIV_CODE_RST;
    mismatch_count      = 0;
    burst_left          = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The directed rows run back to back on the reset configuration.
    for (int r = 0; r < PLAN_ROWS; r++) begin
      send_request(DIRECTED_PLAN[r].target, DIRECTED_PLAN[r].duty,
                   DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].want);
    end

    for (int s = 0; s < FIXED_SETUPS + 2; s++) begin
      // Configuration changes only once the block has gone idle. The setting
      // at index 0 is the reset state, and the block keeps it from reset.
      if (s != 0) begin
        drain_results();
        if (s < FIXED_SETUPS) begin
          setup = CLOCK_SETUPS[s];
        end else if (s == FIXED_SETUPS) begin
          setup.bus_clk = ppc_pkg::CLK_W'($urandom_range(1, 100_000_000));
          setup.code    = ppc_pkg::CODE_W'($urandom_range(0, 7));
        end else begin
          setup.bus_clk = ppc_pkg::CLK_W'($urandom);
          setup.code    = ppc_pkg::CODE_W'($urandom_range(0, 7));
        end
        write_reg(ppc_pkg::CFG_BUS_CLK, ppc_pkg::CFG_DATA_W'(setup.bus_clk));
        write_reg(ppc_pkg::CFG_DIV_CODE, ppc_pkg::CFG_DATA_W'(setup.code));
        // A write to an index past the register list comes after the real
        // writes. If the block took it, the next predictions would fail.
        write_reg(s[0] ? CFG_SPARE_HI : CFG_SPARE_LO, ppc_pkg::CFG_DATA_W'($urandom));
      end

      // The sender works in bursts of 1 to 12 requests. A random gap, or none,
      // comes between bursts. Now and then it waits for every pending word
      // before it goes on.
      for (int i = 0; i < ITEMS_PER_SETUP; i++) begin
        if (burst_left == 0) begin
          if ($urandom_range(0, 24) == 0) begin
            drain_results();
          end else if ($urandom_range(0, 3) != 0) begin
            hold_off($urandom_range(1, 10));
          end
          burst_left = $urandom_range(1, 12);
        end
        send_request(pick_target(), pick_duty(), 1'b0, UNTYPED);
        burst_left--;
      end
    end

    drain_results();
    // Leave the block some extra cycles so that a stray word after the last
    // expected one still gets caught.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("pwm_prescaler_period_calc: match");
    end else begin
      $display("pwm_prescaler_period_calc: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ppc_pkg.sv
hw/rtl/ppc_ifs.sv
hw/rtl/ppc_div.sv
hw/rtl/ppc_dp.sv
hw/rtl/ppc_ctrl.sv
hw/rtl/pwm_prescaler_period_calc.sv
tb/pwm_prescaler_period_calc_tb.sv
